@@ rtl/core/ddsa_pkg.sv @@
`timescale 1ns / 1ps

package ddsa_pkg;

   localparam int SCALAR_BITS   = 24;
   // digit (up to 15) times scalar plus carry, or carry times ten plus digit
   localparam int DIVIDEND_BITS = SCALAR_BITS + 4;
   localparam int STEP_BITS     = $clog2(DIVIDEND_BITS);
   localparam int DIGIT_BITS    = 4;
   localparam int RESIDUE_BITS  = 24;
   localparam int CSR_DATA_BITS = 24;

   localparam logic [SCALAR_BITS-1:0] RADIX      = SCALAR_BITS'(10);
   localparam logic [DIGIT_BITS-1:0]  DIGIT_NINE = DIGIT_BITS'(9);

   typedef enum logic [1:0] {
      OP_MUL = 2'd0,
      OP_DIV = 2'd1,
      OP_ADD = 2'd2
   } op_type;

   typedef enum logic {
      CSR_OPERATION = 1'b0,
      CSR_SCALAR    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

@@ rtl/core/ddsa_divider.sv @@
`timescale 1ns / 1ps

module ddsa_divider (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [ddsa_pkg::DIVIDEND_BITS-1:0]    dividend,
   input  logic [ddsa_pkg::SCALAR_BITS-1:0]      divisor,
   output logic [ddsa_pkg::SCALAR_BITS-1:0]      quotient,
   output logic [ddsa_pkg::SCALAR_BITS-1:0]      remainder,
   output ddsa_pkg::div_status_type              status
);

   logic [ddsa_pkg::DIVIDEND_BITS-1:0] num_ff, num_in;
   logic [ddsa_pkg::SCALAR_BITS-1:0]   rem_ff, rem_in;
   logic [ddsa_pkg::SCALAR_BITS-1:0]   quo_ff, quo_in;
   logic [ddsa_pkg::SCALAR_BITS-1:0]   den_ff, den_in;
   logic [ddsa_pkg::STEP_BITS-1:0]     cnt_ff, cnt_in;
   logic                               run_ff, run_in;
   logic                               done_ff, done_in;

   logic [ddsa_pkg::SCALAR_BITS:0]     trial;
   logic [ddsa_pkg::SCALAR_BITS:0]     diff;
   logic                               fits;

   // one quotient bit a cycle: bring down the next dividend bit, try the subtract
   assign trial = {rem_ff, num_ff[ddsa_pkg::DIVIDEND_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = done_ff;
      if (start) begin
         num_in  = dividend;
         rem_in  = '0;
         quo_in  = '0;
         den_in  = divisor;
         cnt_in  = '0;
         run_in  = 1'b1;
         done_in = 1'b0;
      end else if (run_ff) begin
         num_in = {num_ff[ddsa_pkg::DIVIDEND_BITS-2:0], 1'b0};
         rem_in = fits ? diff[ddsa_pkg::SCALAR_BITS-1:0] : trial[ddsa_pkg::SCALAR_BITS-1:0];
         // high quotient bits fall off the top: only the low word is kept
         quo_in = {quo_ff[ddsa_pkg::SCALAR_BITS-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ddsa_pkg::STEP_BITS'(ddsa_pkg::DIVIDEND_BITS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign quotient    = quo_ff;
   assign remainder   = rem_ff;
   assign status.busy = run_ff;
   assign status.done = done_ff;

endmodule

@@ rtl/core/decimal_digit_serial_arith.sv @@
`timescale 1ns / 1ps

// Digit-serial decimal arithmetic on long numbers, one digit per item and one
// result digit per item. csr index 0 selects the operation (0 multiply by the
// scalar, 1 divide by it, 2 or 3 add digit_b); index 1 sets the scalar.
// Multiply and add take digits least significant first, divide most
// significant first. The carry or remainder runs from item to item and is
// cleared after the item with req_last set. Every operation goes through one
// radix-2 restoring divider (by ten, or by the scalar) that yields one bit a
// cycle over 28 bits. No item is taken while another is in flight: the
// divider loads the dividend as an item is accepted and steps through its
// bits, then the result register loads the result, and only then does
// req_ready rise again. A finished result waits in that register without
// holding up the next item, but the next result stays in the divider, with
// req_ready low, until that register is free. A zero divisor gives digit 9
// and clears the remainder. Write the registers only while no item is in flight.
module decimal_digit_serial_arith (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ddsa_pkg::DIGIT_BITS-1:0]     req_digit_a,
   input  logic [ddsa_pkg::DIGIT_BITS-1:0]     req_digit_b,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ddsa_pkg::DIGIT_BITS-1:0]     rsp_digit,
   output logic [ddsa_pkg::RESIDUE_BITS-1:0]   rsp_residue,
   output logic                                rsp_last_out,
   input  logic                                csr_we,
   input  logic                                csr_index,
   input  logic [ddsa_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [1:0]                          op_ff, op_in;
   logic [ddsa_pkg::SCALAR_BITS-1:0]    scalar_ff, scalar_in;
   logic [ddsa_pkg::SCALAR_BITS-1:0]    carry_ff, carry_in;
   logic                                busy_ff, busy_in;
   logic                                last_ff, last_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [ddsa_pkg::DIGIT_BITS-1:0]     rsp_digit_ff, rsp_digit_in;
   logic [ddsa_pkg::RESIDUE_BITS-1:0]   rsp_residue_ff, rsp_residue_in;
   logic                                rsp_last_ff, rsp_last_in;

   logic                                accept;
   logic                                finish;
   logic [ddsa_pkg::DIVIDEND_BITS-1:0]  dividend;
   logic [ddsa_pkg::DIVIDEND_BITS-1:0]  carry_ext;
   logic [ddsa_pkg::SCALAR_BITS-1:0]    divisor;
   logic [ddsa_pkg::SCALAR_BITS-1:0]    quotient;
   logic [ddsa_pkg::SCALAR_BITS-1:0]    remainder;
   ddsa_pkg::div_status_type            div_status;
   logic [ddsa_pkg::DIGIT_BITS-1:0]     res_digit;
   logic [ddsa_pkg::SCALAR_BITS-1:0]    res_carry;

   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;
   // release the result once the divider is through and the output register is free
   assign finish    = busy_ff && div_status.done && (!rsp_valid_ff || rsp_ready);
   assign carry_ext = ddsa_pkg::DIVIDEND_BITS'(carry_ff);

   always_comb begin
      case (op_ff)
         ddsa_pkg::OP_MUL: begin
            dividend = ddsa_pkg::DIVIDEND_BITS'(req_digit_a)
                     * ddsa_pkg::DIVIDEND_BITS'(scalar_ff) + carry_ext;
            divisor  = ddsa_pkg::RADIX;
         end
         ddsa_pkg::OP_DIV: begin
            dividend = (carry_ext << 3) + (carry_ext << 1)
                     + ddsa_pkg::DIVIDEND_BITS'(req_digit_a);
            divisor  = scalar_ff;
         end
         default: begin
            dividend = ddsa_pkg::DIVIDEND_BITS'(req_digit_a)
                     + ddsa_pkg::DIVIDEND_BITS'(req_digit_b) + carry_ext;
            divisor  = ddsa_pkg::RADIX;
         end
      endcase
   end

   ddsa_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (accept),
      .dividend  (dividend),
      .divisor   (divisor),
      .quotient  (quotient),
      .remainder (remainder),
      .status    (div_status)
   );

   always_comb begin
      if (op_ff == ddsa_pkg::OP_DIV) begin
         if (scalar_ff == '0) begin
            res_digit = ddsa_pkg::DIGIT_NINE;
            res_carry = '0;
         end else begin
            res_digit = quotient[ddsa_pkg::DIGIT_BITS-1:0];
            res_carry = remainder;
         end
      end else begin
         res_digit = remainder[ddsa_pkg::DIGIT_BITS-1:0];
         res_carry = quotient;
      end
   end

   always_comb begin
      op_in          = op_ff;
      scalar_in      = scalar_ff;
      carry_in       = carry_ff;
      busy_in        = busy_ff;
      last_in        = last_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_digit_in   = rsp_digit_ff;
      rsp_residue_in = rsp_residue_ff;
      rsp_last_in    = rsp_last_ff;

      if (csr_we) begin
         case (csr_index)
            ddsa_pkg::CSR_OPERATION: op_in     = csr_wdata[1:0];
            ddsa_pkg::CSR_SCALAR:    scalar_in = csr_wdata[ddsa_pkg::SCALAR_BITS-1:0];
            default:                 op_in     = op_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         busy_in = 1'b1;
         last_in = req_last;
      end

      if (finish) begin
         busy_in        = 1'b0;
         rsp_valid_in   = 1'b1;
         rsp_digit_in   = res_digit;
         rsp_residue_in = ddsa_pkg::RESIDUE_BITS'(res_carry);
         rsp_last_in    = last_ff;
         // drop the carry at the end of a number
         carry_in       = last_ff ? '0 : res_carry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         op_ff        <= ddsa_pkg::OP_ADD;
         scalar_ff    <= ddsa_pkg::SCALAR_BITS'(1);
         carry_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         op_ff        <= op_in;
         scalar_ff    <= scalar_in;
         carry_ff     <= carry_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff        <= last_in;
      rsp_digit_ff   <= rsp_digit_in;
      rsp_residue_ff <= rsp_residue_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_digit    = rsp_digit_ff;
   assign rsp_residue  = rsp_residue_ff;
   assign rsp_last_out = rsp_last_ff;

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import ddsa_pkg::*;

   localparam int IDLE_PERCENT   = 29;
   localparam int RANDOM_ITEMS   = 1600;
   localparam int PHASE_ITEMS    = 50;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 35;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;
   localparam logic [SCALAR_BITS-1:0] SCALAR_MAX = '1;

   typedef struct packed {
      logic [DIGIT_BITS-1:0]   digit;
      logic [RESIDUE_BITS-1:0] residue;
      logic                    last;
   } digit_result_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   logic [DIGIT_BITS-1:0]    req_digit_a;
   logic [DIGIT_BITS-1:0]    req_digit_b;
   logic                     req_last;
   logic                     rsp_valid;
   logic                     rsp_ready;
   logic [DIGIT_BITS-1:0]    rsp_digit;
   logic [RESIDUE_BITS-1:0]  rsp_residue;
   logic                     rsp_last_out;
   logic                     csr_we;
   logic                     csr_index;
   logic [CSR_DATA_BITS-1:0] csr_wdata;

   // predictor state
   logic [1:0]             op_reg;
   logic [SCALAR_BITS-1:0] scalar_reg;
   logic [SCALAR_BITS-1:0] carry_reg;

   digit_result_type pending_digits[$];
   int               mismatch_count = 0;
   int               quiet_cycles   = 0;
   int               hold_seq       = 0;
   bit               no_idle        = 1'b0;

   decimal_digit_serial_arith dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_digit_a  (req_digit_a),
      .req_digit_b  (req_digit_b),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_digit    (rsp_digit),
      .rsp_residue  (rsp_residue),
      .rsp_last_out (rsp_last_out),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic digit_result_type advance_digit(logic [DIGIT_BITS-1:0] da,
                                                      logic [DIGIT_BITS-1:0] db,
                                                      logic lst);
      bit [63:0]        acc;
      bit [63:0]        nxt;
      digit_result_type r;
      if (op_reg[1]) begin
         acc = 64'(da) + 64'(db) + 64'(carry_reg);
         r.digit = DIGIT_BITS'(acc % RADIX);
         nxt = acc / RADIX;
      end else if (op_reg == OP_MUL) begin
         acc = 64'(da) * 64'(scalar_reg) + 64'(carry_reg);
         r.digit = DIGIT_BITS'(acc % RADIX);
         nxt = acc / RADIX;
      end else if (scalar_reg == '0) begin
         r.digit = DIGIT_NINE;
         nxt = '0;
      end else begin
         acc = 64'(carry_reg) * RADIX + 64'(da);
         // quotient wraps to four bits, remainder stays exact
         r.digit = DIGIT_BITS'(acc / scalar_reg);
         nxt = acc % scalar_reg;
      end
      r.residue = RESIDUE_BITS'(nxt[SCALAR_BITS-1:0]);
      r.last    = lst;
      carry_reg = lst ? '0 : nxt[SCALAR_BITS-1:0];
      return r;
   endfunction

   task automatic note_mismatch(string what, digit_result_type want);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t %s: expected digit %0d residue %0d last %0b, got %0d %0d %0b",
                  $realtime, what, want.digit, want.residue, want.last,
                  rsp_digit, rsp_residue, rsp_last_out);
   endtask

   // drop valid, let every result arrive, then let the divider run dry
   task automatic settle;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] data);
      settle();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == CSR_OPERATION) op_reg = data[1:0];
      else scalar_reg = data[SCALAR_BITS-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic send_digit(logic [DIGIT_BITS-1:0] da, logic [DIGIT_BITS-1:0] db,
                             logic lst);
      @(negedge clock);
      while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_digit_a <= da;
      req_digit_b <= db;
      req_last    <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_digits.push_back(advance_digit(da, db, lst));
   endtask

   task automatic test_add;
      write_csr(CSR_OPERATION, CSR_DATA_BITS'(OP_ADD));
      send_digit(4'd9, 4'd9, 1'b0);
      send_digit(4'd9, 4'd9, 1'b0);
      send_digit(4'd0, 4'd0, 1'b1);
      send_digit(4'd15, 4'd15, 1'b1);
      // code three decodes as add
      write_csr(CSR_OPERATION, CSR_DATA_BITS'(3));
      send_digit(4'd8, 4'd7, 1'b1);
   endtask

   task automatic test_multiply;
      write_csr(CSR_OPERATION, CSR_DATA_BITS'(OP_MUL));
      write_csr(CSR_SCALAR, SCALAR_MAX);
      send_digit(4'd15, 4'd0, 1'b0);
      send_digit(4'd9, 4'd15, 1'b0);
      send_digit(4'd0, 4'd0, 1'b1);
      write_csr(CSR_SCALAR, CSR_DATA_BITS'(1));
      send_digit(4'd9, 4'd0, 1'b1);
   endtask

   task automatic test_divide;
      write_csr(CSR_OPERATION, CSR_DATA_BITS'(OP_DIV));
      write_csr(CSR_SCALAR, CSR_DATA_BITS'(7));
      send_digit(4'd9, 4'd0, 1'b0);
      send_digit(4'd15, 4'd0, 1'b0);
      send_digit(4'd3, 4'd0, 1'b1);
      write_csr(CSR_SCALAR, SCALAR_MAX);
      send_digit(4'd9, 4'd0, 1'b0);
      send_digit(4'd15, 4'd0, 1'b1);
      // zero divisor
      write_csr(CSR_SCALAR, '0);
      send_digit(4'd5, 4'd0, 1'b0);
      send_digit(4'd9, 4'd0, 1'b1);
   endtask

   // carry left by one operation is picked up by the next
   task automatic test_mid_number_change;
      write_csr(CSR_OPERATION, CSR_DATA_BITS'(OP_MUL));
      write_csr(CSR_SCALAR, SCALAR_MAX);
      send_digit(4'd9, 4'd0, 1'b0);
      send_digit(4'd9, 4'd0, 1'b0);
      write_csr(CSR_OPERATION, CSR_DATA_BITS'(OP_DIV));
      write_csr(CSR_SCALAR, CSR_DATA_BITS'(3));
      send_digit(4'd4, 4'd0, 1'b0);
      write_csr(CSR_OPERATION, CSR_DATA_BITS'(OP_MUL));
      write_csr(CSR_SCALAR, SCALAR_MAX);
      send_digit(4'd15, 4'd0, 1'b0);
      write_csr(CSR_OPERATION, CSR_DATA_BITS'(OP_ADD));
      send_digit(4'd9, 4'd9, 1'b1);
   endtask

   // receiver holds off while the sender keeps offering items
   task automatic test_backpressure;
      write_csr(CSR_OPERATION, CSR_DATA_BITS'(OP_MUL));
      write_csr(CSR_SCALAR, CSR_DATA_BITS'($urandom));
      no_idle = 1'b1;
      hold_seq++;
      for (int k = 0; k < 24; k++)
         send_digit(4'($urandom_range(9)), 4'($urandom_range(15)), 1'($urandom_range(1)));
      no_idle = 1'b0;
   endtask

   task automatic test_random;
      int                       sent;
      int                       phase;
      int                       phase_items;
      int                       length;
      int                       roll;
      logic [1:0]               op;
      logic [CSR_DATA_BITS-1:0] word;
      logic [DIGIT_BITS-1:0]    da;
      logic [DIGIT_BITS-1:0]    db;
      logic                     lst;
      sent  = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS) begin
         no_idle = (phase >= 8 && phase < 13);
         op   = 2'($urandom_range(3));
         word = CSR_DATA_BITS'(op);
         if ($urandom_range(3) == 0) word = CSR_DATA_BITS'($urandom & 24'hFFFFFC) | word;
         write_csr(CSR_OPERATION, word);
         roll = $urandom_range(19);
         if (roll == 0) word = '0;
         else if (roll <= 2) word = CSR_DATA_BITS'(1);
         else if (roll <= 4) word = SCALAR_MAX;
         else if (roll <= 11) word = CSR_DATA_BITS'($urandom_range(20, 2));
         else word = CSR_DATA_BITS'($urandom >> $urandom_range(31, 8));
         write_csr(CSR_SCALAR, word);
         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            length = $urandom_range(12, 1);
            for (int k = 0; k < length; k++) begin
               da  = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                              : 4'($urandom_range(9));
               db  = ($urandom_range(9) == 0) ? 4'($urandom_range(15))
                                              : 4'($urandom_range(9));
               // leave a few numbers unterminated so the carry runs on
               lst = (k == length - 1) && ($urandom_range(9) != 0);
               send_digit(da, db, lst);
            end
            phase_items += length;
         end
         sent += phase_items;
         phase++;
      end
      no_idle = 1'b0;
   endtask

   initial begin : rsp_side
      int hold_left;
      int hold_seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (no_idle) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   always @(posedge clock) begin : result_check
      digit_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_digits.size() == 0) begin
            note_mismatch("unexpected result", '0);
         end else begin
            want = pending_digits.pop_front();
            if (rsp_digit !== want.digit || rsp_residue !== want.residue ||
                rsp_last_out !== want.last)
               note_mismatch("result mismatch", want);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_digit_a = '0;
      req_digit_b = '0;
      req_last    = 1'b0;
      csr_we      = 1'b0;
      csr_index   = CSR_OPERATION;
      csr_wdata   = '0;
      op_reg      = 2'(OP_ADD);
      scalar_reg  = SCALAR_BITS'(1);
      carry_reg   = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_add();
      test_multiply();
      test_divide();
      test_mid_number_change();
      test_backpressure();
      test_random();

      settle();
      if (mismatch_count == 0 && pending_digits.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/ddsa_pkg.sv
rtl/core/ddsa_divider.sv
rtl/core/decimal_digit_serial_arith.sv
tb/sv/tb_top.sv
